### rtl/raster_bilinear_sampler_assert.svh
// Assertion macros shared by the raster bilinear sampler RTL.
`ifndef RASTER_BILINEAR_SAMPLER_ASSERT_SVH
`define RASTER_BILINEAR_SAMPLER_ASSERT_SVH

// same-cycle implication
`define RBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/rbs_pkg.sv
// Package: constants and types of the raster bilinear sampler.
package rbs_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_BITS    = 24;
    localparam int POS_BITS    = 20;
    localparam int CFG_BITS    = 9;
    localparam int CFG_IDX_BITS = 1;

    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int BANK_AW     = (ROW_BITS - 1) + (COL_BITS - 1);
    localparam int BANK_DEPTH  = (MAX_ROWS * MAX_COLS) / 4;
    localparam int CELL_BITS   = SAMPLE_BITS + 1;
    // signed cell index after the floor of a position
    localparam int IDX_BITS    = POS_BITS + 1 - FRAC_BITS;
    localparam int H_BITS      = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int ACC_BITS    = H_BITS + FRAC_BITS + 2;
    localparam int RES_BITS    = ACC_BITS - FRAC_BITS;

    localparam logic [CFG_BITS-1:0] MAP_RESET = CFG_BITS'(256);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_ROWS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_COLS = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic                          is_null;
        logic signed [SAMPLE_BITS-1:0] value;
    } t_cell;

    // indexed by {row parity, column parity}
    typedef t_cell [3:0] t_quad;

    typedef struct packed {
        logic                 valid;
        logic                 in_range;
        logic                 r_par;
        logic                 c_par;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
    } t_meta;

endpackage

### rtl/rbs_ram.sv
// Generic single-port RAM with registered read.
module rbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule

### rtl/rbs_fetch.sv
// Address generation, bounds check and the four parity-banked raster memories.
module rbs_fetch (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_req_type,
    input  logic [rbs_pkg::ROW_BITS-1:0]         i_cell_row,
    input  logic [rbs_pkg::COL_BITS-1:0]         i_cell_col,
    input  logic signed [rbs_pkg::SAMPLE_BITS-1:0] i_cell_value,
    input  logic                                 i_cell_is_null,
    input  logic signed [rbs_pkg::POS_BITS-1:0]  i_row_pos,
    input  logic signed [rbs_pkg::POS_BITS-1:0]  i_col_pos,
    input  logic [rbs_pkg::IDX_BITS-1:0]         i_rows_eff,
    input  logic [rbs_pkg::IDX_BITS-1:0]         i_cols_eff,
    output rbs_pkg::t_meta                       o_meta,
    output rbs_pkg::t_quad                       o_quad
);
    import rbs_pkg::*;

    localparam logic signed [POS_BITS:0] HALF = (POS_BITS + 1)'(1 << (FRAC_BITS - 1));

    logic signed [POS_BITS:0] rp, cp;
    logic [IDX_BITS-1:0]      r_idx, c_idx, r_nxt, c_nxt;
    logic                     row_ok, col_ok, is_load;
    logic [1:0]               load_bank;
    logic [BANK_AW-1:0]       load_addr;
    t_meta                    r_meta;

    always_comb begin
        rp     = {i_row_pos[POS_BITS-1], i_row_pos} - HALF;
        cp     = {i_col_pos[POS_BITS-1], i_col_pos} - HALF;
        r_idx  = rp[POS_BITS:FRAC_BITS];
        c_idx  = cp[POS_BITS:FRAC_BITS];
        r_nxt  = {1'b0, r_idx[IDX_BITS-2:0]} + IDX_BITS'(1);
        c_nxt  = {1'b0, c_idx[IDX_BITS-2:0]} + IDX_BITS'(1);
        row_ok = !r_idx[IDX_BITS-1] && (r_nxt < i_rows_eff);
        col_ok = !c_idx[IDX_BITS-1] && (c_nxt < i_cols_eff);
        is_load   = (i_req_type == REQ_LOAD);
        load_bank = {i_cell_row[0], i_cell_col[0]};
        load_addr = {i_cell_row[ROW_BITS-1:1], i_cell_col[COL_BITS-1:1]};
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'((b >> 1) & 1);
        localparam logic PC = 1'(b & 1);
        logic [ROW_BITS-2:0] q_row;
        logic [COL_BITS-2:0] q_col;
        logic [BANK_AW-1:0]  addr;
        logic                we;
        t_cell               wcell, rcell;

        always_comb begin
            q_row = r_idx[ROW_BITS-1:1] + (ROW_BITS - 1)'(r_idx[0] & ~PR);
            q_col = c_idx[COL_BITS-1:1] + (COL_BITS - 1)'(c_idx[0] & ~PC);
            addr  = is_load ? load_addr : {q_row, q_col};
            we    = i_accept && is_load && (load_bank == 2'(b));
            wcell.is_null = i_cell_is_null;
            wcell.value   = i_cell_value;
        end

        rbs_ram #(
            .WIDTH (CELL_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (i_accept),
            .i_we    (we),
            .i_addr  (addr),
            .i_wdata (wcell),
            .o_rdata (rcell)
        );

        assign o_quad[b] = rcell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else begin
            r_meta.valid <= i_accept && (i_req_type == REQ_QUERY);
        end
        r_meta.in_range <= row_ok && col_ok;
        r_meta.r_par    <= r_idx[0];
        r_meta.c_par    <= c_idx[0];
        r_meta.fr       <= rp[FRAC_BITS-1:0];
        r_meta.fc       <= cp[FRAC_BITS-1:0];
    end

    assign o_meta = r_meta;
endmodule

### rtl/rbs_blend.sv
// Two-stage bilinear blend: column blend, then row blend with floor and clamp.
module rbs_blend (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rbs_pkg::t_meta                        i_meta,
    input  rbs_pkg::t_quad                        i_quad,
    output logic                                  o_valid,
    output logic signed [rbs_pkg::OUT_BITS-1:0]   o_interp_value,
    output logic                                  o_result_is_null
);
    import rbs_pkg::*;

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);
    localparam logic signed [RES_BITS-1:0] OMAX = RES_BITS'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [RES_BITS-1:0] OMIN = -OMAX - RES_BITS'(1);

    t_cell                    nbr [4];
    logic                     any_null;
    logic [FRAC_BITS:0]       wc0, wc1, wr0, wr1;
    logic signed [H_BITS-1:0] h0, h1;
    logic signed [ACC_BITS-1:0] acc;
    logic signed [RES_BITS-1:0] res;

    logic                     r_b_valid, r_b_null;
    logic [FRAC_BITS-1:0]     r_b_fr;
    logic signed [H_BITS-1:0] r_h0, r_h1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nbr[i] = i_quad[{i_meta.r_par ^ 1'((i >> 1) & 1), i_meta.c_par ^ 1'(i & 1)}];
        end
        any_null = nbr[0].is_null | nbr[1].is_null | nbr[2].is_null | nbr[3].is_null;
        wc1 = {1'b0, i_meta.fc};
        wc0 = ONE - wc1;
        h0  = H_BITS'(nbr[0].value) * H_BITS'($signed({1'b0, wc0}))
            + H_BITS'(nbr[1].value) * H_BITS'($signed({1'b0, wc1}));
        h1  = H_BITS'(nbr[2].value) * H_BITS'($signed({1'b0, wc0}))
            + H_BITS'(nbr[3].value) * H_BITS'($signed({1'b0, wc1}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_meta.valid;
        end
        r_b_null <= !i_meta.in_range || any_null;
        r_b_fr   <= i_meta.fr;
        r_h0     <= h0;
        r_h1     <= h1;
    end

    always_comb begin
        wr1 = {1'b0, r_b_fr};
        wr0 = ONE - wr1;
        acc = ACC_BITS'(r_h0) * ACC_BITS'($signed({1'b0, wr0}))
            + ACC_BITS'(r_h1) * ACC_BITS'($signed({1'b0, wr1}));
        res = acc[ACC_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_b_valid;
        end
        o_result_is_null <= r_b_null;
        if (r_b_null) begin
            o_interp_value <= '0;
        end else if (res > OMAX) begin
            o_interp_value <= OMAX[OUT_BITS-1:0];
        end else if (res < OMIN) begin
            o_interp_value <= OMIN[OUT_BITS-1:0];
        end else begin
            o_interp_value <= res[OUT_BITS-1:0];
        end
    end
endmodule

### rtl/raster_bilinear_sampler.sv
// Top level of the raster bilinear sampler.
//
//   Channel   Handshake                Payload
//   command   start / busy             i_req_type, i_cell_*, i_row_pos, i_col_pos
//   result    o_result_valid strobe    o_interp_value, o_result_is_null
//   config    i_cfg_we                 i_cfg_index, i_cfg_data
//
// One transaction per cycle while not busy; busy is high in reset, cleared after release.
// A query result passes through registered stages: bank read, column
// blend, row blend. Loads write one of four parity banks and give no result.
// Reset clears valid flags, sets busy and the map size; cells are undefined until loaded.
// The receiver cannot stall, so no back-pressure is held anywhere.
module raster_bilinear_sampler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_req_type,
    input  logic [rbs_pkg::ROW_BITS-1:0]           i_cell_row,
    input  logic [rbs_pkg::COL_BITS-1:0]           i_cell_col,
    input  logic signed [rbs_pkg::SAMPLE_BITS-1:0] i_cell_value,
    input  logic                                   i_cell_is_null,
    input  logic signed [rbs_pkg::POS_BITS-1:0]    i_row_pos,
    input  logic signed [rbs_pkg::POS_BITS-1:0]    i_col_pos,
    input  logic                                   i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [rbs_pkg::CFG_BITS-1:0]           i_cfg_data,
    output logic                                   o_result_valid,
    output logic signed [rbs_pkg::OUT_BITS-1:0]    o_interp_value,
    output logic                                   o_result_is_null
);
    import rbs_pkg::*;

    logic [CFG_BITS-1:0] r_map_rows, r_map_cols;
    logic                r_busy;
    logic [IDX_BITS-1:0] rows_eff, cols_eff;
    logic                accept;
    t_meta               meta;
    t_quad               quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_map_rows <= MAP_RESET;
            r_map_cols <= MAP_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAP_ROWS: r_map_rows <= i_cfg_data;
                    CFG_MAP_COLS: r_map_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        busy     = r_busy;
        accept   = start && !r_busy;
        rows_eff = (IDX_BITS'(r_map_rows) > IDX_BITS'(MAX_ROWS)) ?
                   IDX_BITS'(MAX_ROWS) : IDX_BITS'(r_map_rows);
        cols_eff = (IDX_BITS'(r_map_cols) > IDX_BITS'(MAX_COLS)) ?
                   IDX_BITS'(MAX_COLS) : IDX_BITS'(r_map_cols);
    end

    rbs_fetch u_fetch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req_type),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_cell_value   (i_cell_value),
        .i_cell_is_null (i_cell_is_null),
        .i_row_pos      (i_row_pos),
        .i_col_pos      (i_col_pos),
        .i_rows_eff     (rows_eff),
        .i_cols_eff     (cols_eff),
        .o_meta         (meta),
        .o_quad         (quad)
    );

    rbs_blend u_blend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_meta           (meta),
        .i_quad           (quad),
        .o_valid          (o_result_valid),
        .o_interp_value   (o_interp_value),
        .o_result_is_null (o_result_is_null)
    );

`include "raster_bilinear_sampler_assert.svh"

    `RBS_ASSERT_IMP(a_result_from_query, i_clk, i_rst_n, o_result_valid,
        $past(start && !busy && (i_req_type == REQ_QUERY), 3))
    `RBS_ASSERT_IMP(a_null_reads_zero, i_clk, i_rst_n, o_result_valid && o_result_is_null,
        o_interp_value == '0)
    `RBS_ASSERT_NEXT(a_map_holds, i_clk, i_rst_n, !i_cfg_we,
        $stable(r_map_rows) && $stable(r_map_cols))
    `RBS_ASSERT_IMP(a_meta_follows_query, i_clk, i_rst_n, meta.valid,
        $past(accept && (i_req_type == REQ_QUERY), 1))

endmodule
